FILE: hdl/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg
// types and codes shared by the grammar specification tokenizer
// ----------------------------------------------------------------------------
package gst_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned CodeW  = 2;
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);
  localparam int unsigned OutDataW = ((EventW + ByteW + CodeW + 7) / 8) * 8;

  typedef enum logic [EventW-1:0] {
    EV_NEWLINE  = 3'd0,
    EV_DEFINE   = 3'd1,
    EV_NAME_B   = 3'd2,
    EV_NAME_E   = 3'd3,
    EV_PAT_B    = 3'd4,
    EV_PAT_E    = 3'd5,
    EV_EOI      = 3'd6,
    EV_ERROR    = 3'd7
  } event_e;

  typedef enum logic [CodeW-1:0] {
    ERR_UNEXPECTED = 2'd0,
    ERR_BAD_DEF    = 2'd1,
    ERR_ESC_END    = 2'd2,
    ERR_UNCLOSED   = 2'd3
  } err_e;

  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_NAME = 7'b0000010,
    MODE_COL1 = 7'b0000100,
    MODE_COL2 = 7'b0001000,
    MODE_PAT  = 7'b0010000,
    MODE_ESC  = 7'b0100000,
    MODE_ERR  = 7'b1000000
  } mode_e;

  typedef struct packed {
    event_e             ev;
    logic [ByteW-1:0]   data;
    err_e               code;
  } result_t;

  localparam logic [ByteW-1:0] ChColon = 8'h3a;
  localparam logic [ByteW-1:0] ChEqual = 8'h3d;
  localparam logic [ByteW-1:0] ChUnder = 8'h5f;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5c;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChVt    = 8'h0b;
  localparam logic [ByteW-1:0] ChFf    = 8'h0c;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5a;

  function automatic result_t mk_res(event_e ev, logic [ByteW-1:0] data, err_e code);
    result_t r;
    r.ev   = ev;
    r.data = data;
    r.code = code;
    return r;
  endfunction

  function automatic logic is_name(logic [ByteW-1:0] c);
    return ((c >= ChUpA) && (c <= ChUpZ)) || (c == ChUnder);
  endfunction

  function automatic logic is_blank(logic [ByteW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChFf) || (c == ChVt);
  endfunction

endpackage

FILE: hdl/grammar_spec_tokenizer_top.sv
// ----------------------------------------------------------------------------
// grammar_spec_tokenizer_top
// byte-serial tokenizer for grammar specification text
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one text byte per request in tdata, tlast marks the final
//   byte of a text. m_axis carries token events, one per request; tlast marks
//   the last event caused by one input byte.
//   an accepted byte is scanned in the same cycle and its events (zero to
//   three) land in a three-entry result buffer; the first event is shown on
//   m_axis the cycle after acceptance.
//   throughput is one byte per cycle while each byte gives at most one event
//   and m_axis does not stall; a byte with several events holds s_axis while
//   the single read port of the result buffer gives them out one by one.
//   a new byte is taken in the cycle the last buffered event is taken.
//   when m_axis stalls, the buffer holds its events and s_axis_tready drops
//   until the last one is taken.
//   reset clears the buffer and returns the scanner to idle between tokens.
// ----------------------------------------------------------------------------
module grammar_spec_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [gst_pkg::OutDataW-1:0] m_axis_tdata, // [2:0] event_res, [10:3] data_byte,
                                                     // [12:11] error_code, zero above
  output logic        m_axis_tlast    // run_end
);

  gst_pkg::mode_e   mode_q, mode_d;
  gst_pkg::result_t buf_q [gst_pkg::MaxRes];
  gst_pkg::result_t res   [gst_pkg::MaxRes];
  logic [gst_pkg::CntW-1:0] cnt_q, res_cnt;
  logic [gst_pkg::IdxW-1:0] rd_q;
  logic [gst_pkg::IdxW-1:0] last_idx;
  logic                     in_acc, out_acc, out_end;
  logic [gst_pkg::ByteW-1:0] c;

  assign c = s_axis_tdata;

  // scanner
  always_comb begin
    logic do_idle;
    gst_pkg::mode_e m;
    logic [gst_pkg::CntW-1:0] n;
    do_idle = 1'b0;
    m = mode_q;
    n = '0;
    for (int i = 0; i < gst_pkg::MaxRes; i++) begin
      res[i] = gst_pkg::mk_res(gst_pkg::EV_NEWLINE, '0, gst_pkg::ERR_UNEXPECTED);
    end
    case (mode_q)
      gst_pkg::MODE_NAME: begin
        if (gst_pkg::is_name(c)) begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_NAME_B, c,
                                                      gst_pkg::ERR_UNEXPECTED);
          n = n + 1'b1;
        end else begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_NAME_E, '0,
                                                      gst_pkg::ERR_UNEXPECTED);
          n = n + 1'b1;
          m = gst_pkg::MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      gst_pkg::MODE_COL1: begin
        if (c == gst_pkg::ChColon) begin
          m = gst_pkg::MODE_COL2;
        end else begin
          m = gst_pkg::MODE_ERR;
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_ERROR, '0,
                                                      gst_pkg::ERR_BAD_DEF);
          n = n + 1'b1;
        end
      end
      gst_pkg::MODE_COL2: begin
        if (c == gst_pkg::ChEqual) begin
          m = gst_pkg::MODE_IDLE;
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_DEFINE, '0,
                                                      gst_pkg::ERR_UNEXPECTED);
        end else begin
          m = gst_pkg::MODE_ERR;
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_ERROR, '0,
                                                      gst_pkg::ERR_BAD_DEF);
        end
        n = n + 1'b1;
      end
      gst_pkg::MODE_PAT: begin
        if (c == gst_pkg::ChBslash) begin
          m = gst_pkg::MODE_ESC;
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_PAT_B, c,
                                                      gst_pkg::ERR_UNEXPECTED);
        end else if (c == gst_pkg::ChQuote) begin
          m = gst_pkg::MODE_IDLE;
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_PAT_E, '0,
                                                      gst_pkg::ERR_UNEXPECTED);
        end else begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_PAT_B, c,
                                                      gst_pkg::ERR_UNEXPECTED);
        end
        n = n + 1'b1;
      end
      gst_pkg::MODE_ESC: begin
        m = gst_pkg::MODE_PAT;
        res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_PAT_B, c,
                                                    gst_pkg::ERR_UNEXPECTED);
        n = n + 1'b1;
      end
      gst_pkg::MODE_ERR: begin
        m = gst_pkg::MODE_ERR;
      end
      default: begin
        m = gst_pkg::MODE_IDLE;
        do_idle = 1'b1;
      end
    endcase

    // byte seen between tokens
    if (do_idle) begin
      if (gst_pkg::is_blank(c)) begin
        m = gst_pkg::MODE_IDLE;
      end else if (c == gst_pkg::ChLf) begin
        res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_NEWLINE, '0,
                                                    gst_pkg::ERR_UNEXPECTED);
        n = n + 1'b1;
      end else if (c == gst_pkg::ChQuote) begin
        m = gst_pkg::MODE_PAT;
      end else if (gst_pkg::is_name(c)) begin
        m = gst_pkg::MODE_NAME;
        res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_NAME_B, c,
                                                    gst_pkg::ERR_UNEXPECTED);
        n = n + 1'b1;
      end else if (c == gst_pkg::ChColon) begin
        m = gst_pkg::MODE_COL1;
      end else begin
        m = gst_pkg::MODE_ERR;
        res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_ERROR, '0,
                                                    gst_pkg::ERR_UNEXPECTED);
        n = n + 1'b1;
      end
    end

    // end of text
    if (s_axis_tlast) begin
      case (m)
        gst_pkg::MODE_NAME: begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_NAME_E, '0,
                                                      gst_pkg::ERR_UNEXPECTED);
          n = n + 1'b1;
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_EOI, '0,
                                                      gst_pkg::ERR_UNEXPECTED);
          n = n + 1'b1;
        end
        gst_pkg::MODE_COL1, gst_pkg::MODE_COL2: begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_ERROR, '0,
                                                      gst_pkg::ERR_BAD_DEF);
          n = n + 1'b1;
        end
        gst_pkg::MODE_ESC: begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_ERROR, '0,
                                                      gst_pkg::ERR_ESC_END);
          n = n + 1'b1;
        end
        gst_pkg::MODE_PAT: begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_ERROR, '0,
                                                      gst_pkg::ERR_UNCLOSED);
          n = n + 1'b1;
        end
        gst_pkg::MODE_ERR: begin
          n = n;
        end
        default: begin
          res[n[gst_pkg::IdxW-1:0]] = gst_pkg::mk_res(gst_pkg::EV_EOI, '0,
                                                      gst_pkg::ERR_UNEXPECTED);
          n = n + 1'b1;
        end
      endcase
      m = gst_pkg::MODE_IDLE;
    end

    mode_d  = m;
    res_cnt = n;
  end

  // result buffer control
  assign last_idx      = gst_pkg::IdxW'(cnt_q - 1'b1);
  assign m_axis_tvalid = (cnt_q != '0);
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign out_end       = out_acc & (rd_q == last_idx);
  assign s_axis_tready = (cnt_q == '0) | out_end;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign m_axis_tdata = gst_pkg::OutDataW'({buf_q[rd_q].code, buf_q[rd_q].data,
                                            buf_q[rd_q].ev});
  assign m_axis_tlast = (rd_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= gst_pkg::MODE_IDLE;
      cnt_q  <= '0;
      rd_q   <= '0;
    end else begin
      if (in_acc) begin
        mode_q <= mode_d;
        cnt_q  <= res_cnt;
        rd_q   <= '0;
      end else if (out_end) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else if (out_acc) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < gst_pkg::MaxRes; i++) begin
        buf_q[i] <= res[i];
      end
    end
  end

  // checks
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (gst_pkg::CntW'(rd_q) < cnt_q))
    else $error("read index past buffered results");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> s_axis_tready)
    else $error("empty buffer refuses input");

  a_silent_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (res_cnt == '0)) |=> !m_axis_tvalid)
    else $error("result shown for a byte without events");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (res_cnt <= gst_pkg::CntW'(gst_pkg::MaxRes)))
    else $error("too many results for one byte");

endmodule
